>>> design/smt_pkg.sv
// shared types and constants for the sorted multiset table
// no dependencies; read first by the compiler
package smt_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned COUNT_W      = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_LOOKUP = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_FIN  = 4'b0100,
    ST_RESP = 4'b1000
  } state_t;

endpackage

>>> design/smt_if.sv
// valid/ready channel interfaces for the sorted multiset table
// depends on smt_pkg for field widths
interface smt_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          op;
  logic signed [smt_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface smt_out_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [smt_pkg::COUNT_W-1:0]   entry_count;
  logic                          tbl_empty;
  logic                          status;

  modport source (output valid, output found, output entry_count, output tbl_empty,
                  output status, input ready);
  modport sink   (input valid, input found, input entry_count, input tbl_empty,
                  input status, output ready);
endinterface

>>> design/sorted_multiset_table_core.sv
// top level of the sorted multiset table: sequencer, entry memory, result register
// depends on smt_pkg and the channel interfaces in smt_if.sv
//
// in_ch carries one operation (insert, delete all copies, clear, lookup) and a signed
// 32-bit value; each transaction yields exactly one result on out_ch with found,
// entry_count, tbl_empty and status (insert dropped, table full)
// entries sit in a registered-read memory in ascending order; one shared signed
// comparator walks the occupied entries, one per cycle, doing the match test and
// the in-place shift or compaction
// sequence: after acceptance the scan steps through the occupied entries (memory
//   read is registered), then ST_FIN does the tail write and count update and
//   ST_RESP loads the result register
// ready returns with the result, so a new transaction is taken only once the
//   last one is through
// reset: rst_n low empties the table (count to zero) and drops any result held;
//   memory contents are left as they are and never read until rewritten
// stall: in_ch.ready is high only while the sequencer is idle; a result waiting
//   on out_ch does not stop a new transaction being taken, but the sequencer
//   holds before its result stage until the output register is free
module sorted_multiset_table_core #(
  parameter int unsigned CAPACITY = smt_pkg::CAPACITY_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  smt_in_if.sink   in_ch,
  smt_out_if.source out_ch
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  // entry memory, reset value undefined
  logic signed [smt_pkg::VALUE_W-1:0] mem [CAPACITY];
  logic signed [smt_pkg::VALUE_W-1:0] rdata_r;

  // sequencer state
  smt_pkg::state_t state_r, state_nxt;
  smt_pkg::op_t    op_r, op_nxt;
  logic signed [smt_pkg::VALUE_W-1:0] key_r, key_nxt;
  logic signed [smt_pkg::VALUE_W-1:0] hold_r, hold_nxt;
  logic [CW-1:0] occ_r, occ_nxt;
  logic [CW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] wr_r, wr_nxt;
  logic          pend_r, pend_nxt;
  logic          found_r, found_nxt;
  logic          placed_r, placed_nxt;
  logic          full_r, full_nxt;

  // result register
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_found_r, out_found_nxt;
  logic [smt_pkg::COUNT_W-1:0] out_count_r, out_count_nxt;
  logic                        out_empty_r, out_empty_nxt;
  logic                        out_status_r, out_status_nxt;

  // memory port controls
  logic                               rd_en;
  logic [AW-1:0]                      rd_addr;
  logic                               we;
  logic [AW-1:0]                      wa;
  logic signed [smt_pkg::VALUE_W-1:0] wd;

  // shared comparator on the entry just read
  logic eq_key, gt_key;
  assign eq_key = (rdata_r == key_r);
  assign gt_key = (rdata_r > key_r);

  logic in_fire, out_fire;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_valid_r && out_ch.ready;

  assign in_ch.ready        = (state_r == smt_pkg::ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.entry_count = out_count_r;
  assign out_ch.tbl_empty   = out_empty_r;
  assign out_ch.status      = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    hold_nxt       = hold_r;
    occ_nxt        = occ_r;
    rd_nxt         = rd_r;
    wr_nxt         = wr_r;
    pend_nxt       = pend_r;
    found_nxt      = found_r;
    placed_nxt     = placed_r;
    full_nxt       = full_r;
    out_valid_nxt  = out_fire ? 1'b0 : out_valid_r;
    out_found_nxt  = out_found_r;
    out_count_nxt  = out_count_r;
    out_empty_nxt  = out_empty_r;
    out_status_nxt = out_status_r;
    rd_en          = 1'b0;
    rd_addr        = rd_r[AW-1:0];
    we             = 1'b0;
    wa             = wr_r[AW-1:0];
    wd             = rdata_r;

    case (state_r)
      smt_pkg::ST_IDLE: begin
        if (in_fire) begin
          op_nxt     = smt_pkg::op_t'(in_ch.op);
          key_nxt    = in_ch.value;
          rd_nxt     = '0;
          wr_nxt     = '0;
          pend_nxt   = 1'b0;
          found_nxt  = 1'b0;
          placed_nxt = 1'b0;
          full_nxt   = (occ_r == CAP_C);
          state_nxt  = smt_pkg::ST_SCAN;
        end
      end
      smt_pkg::ST_SCAN: begin
        // issue the next read ahead of the write pointer
        if (rd_r != occ_r) begin
          rd_en    = 1'b1;
          rd_nxt   = rd_r + 1'b1;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          if (eq_key) begin
            found_nxt = 1'b1;
          end
          case (op_r)
            smt_pkg::OP_INSERT: begin
              if (!full_r) begin
                if (placed_r) begin
                  // ripple the held entry up one slot
                  we       = 1'b1;
                  wd       = hold_r;
                  hold_nxt = rdata_r;
                end else if (gt_key) begin
                  // first entry above the key: key goes here
                  we         = 1'b1;
                  wd         = key_r;
                  hold_nxt   = rdata_r;
                  placed_nxt = 1'b1;
                end
                wr_nxt = wr_r + 1'b1;
              end
            end
            smt_pkg::OP_DELETE: begin
              // compaction: keep every entry that is not a copy
              if (!eq_key) begin
                we     = 1'b1;
                wr_nxt = wr_r + 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        // all reads issued: the last entry (if any) is handled this cycle
        if (rd_r == occ_r) begin
          state_nxt = smt_pkg::ST_FIN;
        end
      end
      smt_pkg::ST_FIN: begin
        case (op_r)
          smt_pkg::OP_INSERT: begin
            if (!full_r) begin
              we      = 1'b1;
              wa      = occ_r[AW-1:0];
              wd      = placed_r ? hold_r : key_r;
              occ_nxt = occ_r + 1'b1;
            end
          end
          smt_pkg::OP_DELETE: occ_nxt = wr_r;
          smt_pkg::OP_CLEAR:  occ_nxt = '0;
          default: begin
          end
        endcase
        state_nxt = smt_pkg::ST_RESP;
      end
      smt_pkg::ST_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = found_r;
          out_count_nxt  = smt_pkg::COUNT_W'(occ_r);
          out_empty_nxt  = (occ_r == '0);
          out_status_nxt = (op_r == smt_pkg::OP_INSERT) && full_r;
          state_nxt      = smt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = smt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= smt_pkg::ST_IDLE;
      occ_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    hold_r       <= hold_nxt;
    rd_r         <= rd_nxt;
    wr_r         <= wr_nxt;
    found_r      <= found_nxt;
    placed_r     <= placed_nxt;
    full_r       <= full_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
    out_empty_r  <= out_empty_nxt;
    out_status_r <= out_status_nxt;
  end

  // entry memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // count never passes capacity
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CAP_C)
    else $error("entry count above capacity");

  // writes during the scan stay strictly behind the read pointer
  a_write_behind: assert property (@(posedge clk) disable iff (!rst_n)
    (we && state_r == smt_pkg::ST_SCAN) |-> (wr_r < rd_r))
    else $error("scan write overtook read pointer");

  // read pointer never runs past the occupied entries
  a_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == smt_pkg::ST_SCAN) |-> (rd_r <= occ_r))
    else $error("scan read beyond occupied entries");

  // a dropped insert only ever reports a full table
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == smt_pkg::ST_RESP && op_r == smt_pkg::OP_INSERT && full_r)
      |-> (occ_r == CAP_C))
    else $error("insert dropped without a full table");

endmodule
